>>> src/lms_pkg.sv
`timescale 1ns / 1ps

package lms_pkg;

    // Geometry defaults
    localparam int ROW_COUNT_DEF = 8;
    localparam int ROW_BYTES_DEF = 8;

    // Field and register widths
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int BRIGHT_W   = 7;
    localparam int PERIOD_W   = 16;
    localparam int PROD_W     = PERIOD_W + BRIGHT_W;
    localparam int COL_W      = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 1'd1;

    // Function codes of an input item
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_SWAP  = 2'd2;

    // Register reset values and limits
    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL  = 7'd100;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^23
    localparam int              RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
    localparam int              RECIP_SHIFT = 30;

    // On-time pipeline depth, ready is held low after a write while the pipeline settles
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_SWAP  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] byte_addr;
        logic [7:0] byte_data;
    } item_t;

    typedef struct packed {
        logic [2:0]       row_select;
        logic [COL_W-1:0] column_bits;
        logic             lit;
        logic             swap_done;
        logic             swap_waiting;
    } result_t;

    // Classified item passed from the front end to the scan engine
    typedef struct packed {
        op_t        op;
        logic       row_ok;
        logic [2:0] row;
        logic [2:0] byte_idx;
        logic [7:0] data;
    } cmd_t;

    // Slot timing seen by the scan engine
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] off;
    } timing_t;

endpackage

>>> src/lms_timing.sv
`timescale 1ns / 1ps

module lms_timing (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lms_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [lms_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output lms_pkg::timing_t               timing,
    output logic                           busy
);
    import lms_pkg::*;

    logic [BRIGHT_W-1:0]        bright_reg, bright_next;
    logic [PERIOD_W-1:0]        period_reg, period_next;
    logic [1:0]                 settle_reg, settle_next;
    logic [PERIOD_W-1:0]        period_eff;
    logic [BRIGHT_W-1:0]        bright_sat;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [PERIOD_W-1:0]        p1_period_reg;
    logic [PROD_W+RECIP_W-1:0]  scaled;
    logic [PERIOD_W-1:0]        on_reg, on_next;
    logic [PERIOD_W-1:0]        p2_period_reg;
    logic [PERIOD_W-1:0]        off_reg, off_next;
    logic [PERIOD_W-1:0]        p3_period_reg;

    // Register writes
    always_comb
    begin
        bright_next = bright_reg;
        period_next = period_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BRIGHTNESS: bright_next = cfg_wdata[BRIGHT_W-1:0];
                CFG_PERIOD:     period_next = cfg_wdata[PERIOD_W-1:0];
                default:        ;
            endcase
        end
    end

    // Settle count covers the three on-time stages
    always_comb
    begin
        if (cfg_we)
            settle_next = SETTLE_CYCLES;
        else if (settle_reg != 2'd0)
            settle_next = settle_reg - 2'd1;
        else
            settle_next = settle_reg;
    end

    assign busy = cfg_we || (settle_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= BRIGHT_RESET;
            period_reg <= PERIOD_RESET;
            settle_reg <= SETTLE_CYCLES;
        end
        else
        begin
            bright_reg <= bright_next;
            period_reg <= period_next;
            settle_reg <= settle_next;
        end
    end

    // Stage 1: zero period counts as one tick, brightness saturates at full
    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign bright_sat = (bright_reg > BRIGHT_FULL) ? BRIGHT_FULL : bright_reg;
    assign prod_next  = PROD_W'(period_eff) * PROD_W'(bright_sat);

    // Stage 2: divide by 100 through the reciprocal
    assign scaled  = (PROD_W+RECIP_W)'(prod_reg) * (PROD_W+RECIP_W)'(RECIP_100);
    assign on_next = scaled[RECIP_SHIFT +: PERIOD_W];

    // Stage 3: blanking length
    assign off_next = p2_period_reg - on_reg;

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        p1_period_reg <= period_eff;
        on_reg        <= on_next;
        p2_period_reg <= p1_period_reg;
        off_reg       <= off_next;
        p3_period_reg <= p2_period_reg;
    end

    assign timing.period = p3_period_reg;
    assign timing.off    = off_reg;

endmodule

>>> src/lms_front.sv
`timescale 1ns / 1ps

module lms_front #(
    parameter int ROW_COUNT = lms_pkg::ROW_COUNT_DEF,
    parameter int ROW_BYTES = lms_pkg::ROW_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  lms_pkg::item_t item,
    input  logic           busy,
    output logic           push_valid,
    input  logic           push_ready,
    output lms_pkg::cmd_t  push_cmd
);
    import lms_pkg::*;

    localparam logic [5:0] RowCountV = 6'(ROW_COUNT);

    logic       valid_reg, valid_next;
    cmd_t       cmd_reg;
    cmd_t       cmd_new;
    logic       accept;
    logic [5:0] addr_row;
    logic [5:0] addr_byte;

    // Split the byte address into row and byte within the row,
    // by comparing against the start address of each row
    always_comb
    begin
        addr_row  = '0;
        addr_byte = item.byte_addr;
        for (int r = 1; r <= ROW_COUNT; r++)
        begin
            if ({1'b0, item.byte_addr} >= 7'(r * ROW_BYTES))
            begin
                addr_row  = 6'(r);
                addr_byte = item.byte_addr - 6'(r * ROW_BYTES);
            end
        end
    end

    // Classify the item
    always_comb
    begin
        unique case (item.func)
            FUNC_TICK:  cmd_new.op = OP_TICK;
            FUNC_WRITE: cmd_new.op = OP_WRITE;
            FUNC_SWAP:  cmd_new.op = OP_SWAP;
            default:    cmd_new.op = OP_NONE;
        endcase
        cmd_new.row_ok   = addr_row < RowCountV;
        cmd_new.row      = addr_row[2:0];
        cmd_new.byte_idx = addr_byte[2:0];
        cmd_new.data     = item.byte_data;
    end

    assign item_ready = !busy && (!valid_reg || push_ready);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (push_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_new;
    end

    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

endmodule

>>> src/lms_queue.sv
`timescale 1ns / 1ps

module lms_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  lms_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output lms_pkg::cmd_t pop_cmd
);
    import lms_pkg::*;

    localparam int CNT_W = QPTR_W + 1;

    cmd_t              store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> src/lms_back.sv
`timescale 1ns / 1ps

module lms_back #(
    parameter int ROW_COUNT = lms_pkg::ROW_COUNT_DEF,
    parameter int ROW_BYTES = lms_pkg::ROW_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  lms_pkg::cmd_t    cmd,
    input  lms_pkg::timing_t timing,
    output logic             result_valid,
    input  logic             result_ready,
    output lms_pkg::result_t result
);
    import lms_pkg::*;

    localparam int ROW_W   = $clog2(ROW_COUNT);
    localparam int ENTRIES = 2 * ROW_COUNT;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int DATA_W  = 8 * ROW_BYTES;

    logic [DATA_W-1:0]   store_reg [ENTRIES];
    logic                bank_reg, bank_next;
    logic                pending_reg, pending_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [PERIOD_W-1:0] tick_reg, tick_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                step;
    logic                is_tick;
    logic                is_write;
    logic                is_swap;
    logic                do_swap;
    logic                do_write;
    logic                bank_now;
    logic                shown;
    logic [ROW_W-1:0]    cmd_row;
    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    wr_idx;
    logic [PERIOD_W:0]   tick_inc;

    assign pop_ready = !out_valid_reg || result_ready;
    assign step      = pop_valid && pop_ready;
    assign is_tick   = cmd.op == OP_TICK;
    assign is_write  = cmd.op == OP_WRITE;
    assign is_swap   = cmd.op == OP_SWAP;

    // Pending swap takes effect on the first tick of a frame
    assign do_swap  = is_tick && (row_reg == '0) && (tick_reg == '0) && pending_reg;
    assign bank_now = bank_reg ^ do_swap;
    assign do_write = step && is_write && cmd.row_ok;

    // Store addressing, bank b row r at entry b*ROW_COUNT+r; writes go to the back bank
    assign cmd_row = cmd.row[ROW_W-1:0];
    assign rd_idx  = bank_now ? IDX_W'(ROW_COUNT) + IDX_W'(row_reg) : IDX_W'(row_reg);
    assign wr_idx  = bank_reg ? IDX_W'(cmd_row) : IDX_W'(ROW_COUNT) + IDX_W'(cmd_row);

    // Lit once the blanking part of the slot has passed
    assign shown    = tick_reg >= timing.off;
    assign tick_inc = {1'b0, tick_reg} + (PERIOD_W+1)'(1);

    // Scan position and bank state
    always_comb
    begin
        bank_next    = bank_reg;
        pending_next = pending_reg;
        row_next     = row_reg;
        tick_next    = tick_reg;
        if (step)
        begin
            bank_next = bank_now;
            if (is_swap)
                pending_next = 1'b1;
            else if (do_swap)
                pending_next = 1'b0;
            if (is_tick)
            begin
                if (tick_inc >= {1'b0, timing.period})
                begin
                    tick_next = '0;
                    row_next  = (row_reg == ROW_W'(ROW_COUNT - 1)) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    tick_next = tick_inc[PERIOD_W-1:0];
                end
            end
        end
    end

    // Result register
    always_comb
    begin
        out_next.row_select   = 3'(row_reg);
        out_next.column_bits  = shown ? COL_W'(store_reg[rd_idx]) : '0;
        out_next.lit          = shown;
        out_next.swap_done    = do_swap;
        out_next.swap_waiting = (pending_reg && !do_swap) || is_swap;
    end

    always_comb
    begin
        if (step)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg      <= 1'b0;
            pending_reg   <= 1'b0;
            row_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bank_reg      <= bank_next;
            pending_reg   <= pending_next;
            row_reg       <= row_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= out_next;
    end

    // Frame store, byte writes into the back bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < ENTRIES; e++)
                store_reg[e] <= '0;
        end
        else if (do_write)
        begin
            for (int k = 0; k < ROW_BYTES; k++)
            begin
                if (cmd.byte_idx == 3'(k))
                    store_reg[wr_idx][k*8 +: 8] <= cmd.data;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

>>> src/led_matrix_row_scanner_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready     item_t: func, byte_addr, byte_data
// result    out        result_valid / result_ready result_t: row, columns, lit, swap flags
// cfg       in         cfg_we                      cfg_addr, cfg_wdata
//
// One item per cycle sustained while results are taken and the on-time pipeline is
// not settling; a taken item passes the front register, command queue and result
// register before its result appears. item_ready is low after reset and after each
// register write while the on-time pipeline (multiply, divide by 100, subtract) settles.
// A stalled result holds the scan engine; the queue and front register absorb
// up to three further items before item_ready drops.

module led_matrix_row_scanner_top #(
    parameter int ROW_COUNT = lms_pkg::ROW_COUNT_DEF,
    parameter int ROW_BYTES = lms_pkg::ROW_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  lms_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output lms_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [lms_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [lms_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lms_pkg::*;

    timing_t timing;
    logic    busy;
    logic    push_valid;
    logic    push_ready;
    cmd_t    push_cmd;
    logic    pop_valid;
    logic    pop_ready;
    cmd_t    pop_cmd;

    // Registers and on-time computation
    lms_timing u_timing (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .timing    (timing),
        .busy      (busy)
    );

    // Accept and classify
    lms_front #(
        .ROW_COUNT (ROW_COUNT),
        .ROW_BYTES (ROW_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .busy       (busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Command queue
    lms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Scan engine and frame store
    lms_back #(
        .ROW_COUNT (ROW_COUNT),
        .ROW_BYTES (ROW_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .cmd          (pop_cmd),
        .timing       (timing),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Blanked rows drive no columns
    a_blank_dark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.lit |-> result.column_bits == '0)
        else $error("columns driven while blanked");

    // A completed swap is never still reported as waiting
    a_swap_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.swap_done |-> !result.swap_waiting)
        else $error("swap done and waiting together");

    // Row select stays within the matrix
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> {1'b0, result.row_select} < 4'(ROW_COUNT))
        else $error("row select out of range");

    // No item is taken while the on-time pipeline settles after a write
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !item_ready)
        else $error("item accepted during register settle");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import lms_pkg::*;

    localparam int ROWS        = ROW_COUNT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_WAIT = 6;
    localparam int PHASE_ITEMS = 75;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic      item_valid   = 1'b0;
    logic      item_ready;
    item_t     item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    result_t   result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Scan state mirrored from the block
    logic [COL_W-1:0]    bank_rows [16];
    logic                front_sel;
    logic                swap_req;
    logic [2:0]          scan_row;
    logic [PERIOD_W-1:0] scan_tick;
    logic [BRIGHT_W-1:0] bright_reg;
    logic [PERIOD_W-1:0] period_reg;

    result_t expected_results [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    bit      src_idle_en    = 1'b1;
    bit      sink_idle_en   = 1'b1;
    int      sink_hold      = 0;

    led_matrix_row_scanner_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    function automatic item_t make_item(op_t f, logic [5:0] addr, logic [7:0] data);
        item_t it;
        it.func      = f;
        it.byte_addr = addr;
        it.byte_data = data;
        return it;
    endfunction

    task automatic reset_scan_state();
        for (int i = 0; i < 16; i++)
            bank_rows[i] = '0;
        front_sel  = 1'b0;
        swap_req   = 1'b0;
        scan_row   = '0;
        scan_tick  = '0;
        bright_reg = BRIGHT_RESET;
        period_reg = PERIOD_RESET;
    endtask

    // Predict the result of one item and advance the mirrored state
    function automatic result_t scan_predict(item_t it);
        result_t r;
        int per;
        int bri;
        int off;
        logic done;
        per  = (period_reg == 0) ? 1 : int'(period_reg);
        bri  = (bright_reg > BRIGHT_FULL) ? int'(BRIGHT_FULL) : int'(bright_reg);
        off  = per - (per * bri) / 100;
        done = 1'b0;
        // swap only lands on the first tick of a frame
        if (it.func == OP_TICK && scan_row == 0 && scan_tick == 0 && swap_req)
        begin
            front_sel = ~front_sel;
            swap_req  = 1'b0;
            done      = 1'b1;
        end
        if (it.func == OP_WRITE)
            bank_rows[{~front_sel, it.byte_addr[5:3]}][it.byte_addr[2:0] * 8 +: 8] = it.byte_data;
        if (it.func == OP_SWAP)
            swap_req = 1'b1;
        r.row_select   = scan_row;
        r.lit          = (int'(scan_tick) >= off);
        r.column_bits  = r.lit ? bank_rows[{front_sel, scan_row}] : '0;
        r.swap_done    = done;
        r.swap_waiting = swap_req;
        if (it.func == OP_TICK)
        begin
            if (int'(scan_tick) + 1 >= per)
            begin
                scan_tick = '0;
                scan_row  = (scan_row == ROWS - 1) ? 3'd0 : scan_row + 3'd1;
            end
            else
                scan_tick = scan_tick + 1'b1;
        end
        return r;
    endfunction

    // Send one item, record its expected result once taken
    task automatic send_item(item_t it);
        int gap;
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
        expected_results.push_back(scan_predict(it));
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the source until every expected result is back
    task automatic wait_drain();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == CFG_BRIGHTNESS)
            bright_reg = val[BRIGHT_W-1:0];
        else
            period_reg = val[PERIOD_W-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic [BRIGHT_W-1:0] b, logic [PERIOD_W-1:0] p,
                              logic [8:0] upper);
        wait_drain();
        cfg_write(CFG_BRIGHTNESS, {upper, b});
        cfg_write(CFG_PERIOD, p);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s at cycle %0d: got %h, want %h", what, cycle_count, got, want);
        mismatch_count++;
    endtask

    // Result sink with random stalls
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            result_ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else if (sink_idle_en && $urandom_range(0, 99) < 25)
        begin
            result_ready <= 1'b0;
            sink_hold = pick_gap();
        end
        else
            result_ready <= 1'b1;
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid === 1'b1 && result_ready === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", result.column_bits, '0);
            else
            begin
                want = expected_results.pop_front();
                if (result.row_select !== want.row_select)
                    report_mismatch("row_select", 64'(result.row_select),
                                    64'(want.row_select));
                if (result.column_bits !== want.column_bits)
                    report_mismatch("column_bits", result.column_bits, want.column_bits);
                if (result.lit !== want.lit)
                    report_mismatch("lit", 64'(result.lit), 64'(want.lit));
                if (result.swap_done !== want.swap_done)
                    report_mismatch("swap_done", 64'(result.swap_done), 64'(want.swap_done));
                if (result.swap_waiting !== want.swap_waiting)
                    report_mismatch("swap_waiting", 64'(result.swap_waiting),
                                    64'(want.swap_waiting));
            end
        end
    end

    // Swap pending at the very first tick after reset, default registers
    task automatic test_after_reset();
        send_item(make_item(OP_WRITE, 6'd0, 8'hA5));
        send_item(make_item(OP_SWAP, 6'd0, 8'h00));
        send_item(make_item(OP_TICK, 6'd0, 8'h00));
        send_item(make_item(OP_NONE, 6'd0, 8'h00));
        send_item(make_item(OP_TICK, 6'd0, 8'h00));
    endtask

    // Dark, saturated and half brightness
    task automatic test_brightness_edges();
        set_config(7'd0, 16'd4, 9'd0);
        repeat (4) send_item(make_item(OP_TICK, 6'd0, 8'h00));
        set_config(7'd127, 16'd4, 9'd0);
        repeat (2) send_item(make_item(OP_TICK, 6'd0, 8'h00));
        set_config(7'd50, 16'd3, 9'h1FF);
        repeat (3) send_item(make_item(OP_TICK, 6'd0, 8'h00));
    endtask

    // Extreme addresses and data, merged swap requests, unused code
    task automatic test_field_extremes();
        send_item(make_item(OP_WRITE, 6'd63, 8'hFF));
        send_item(make_item(OP_WRITE, 6'd0, 8'h00));
        send_item(make_item(OP_SWAP, 6'd63, 8'hFF));
        send_item(make_item(OP_SWAP, 6'd0, 8'h00));
        send_item(make_item(OP_NONE, 6'd63, 8'hFF));
    endtask

    // Zero period, and a period lowered beneath the current position
    task automatic test_period_edges();
        set_config(7'd100, 16'd0, 9'd0);
        repeat (2) send_item(make_item(OP_TICK, 6'd0, 8'h00));
        set_config(7'd60, 16'd20, 9'd0);
        repeat (5) send_item(make_item(OP_TICK, 6'd0, 8'h00));
        set_config(7'd60, 16'd3, 9'd0);
        repeat (2) send_item(make_item(OP_TICK, 6'd0, 8'h00));
    endtask

    // Random traffic over several register settings
    task automatic test_random_phases();
        logic [BRIGHT_W-1:0] b;
        logic [PERIOD_W-1:0] p;
        int n;
        int r;
        int burst;
        logic [5:0] base;
        for (int phase = 0; phase < 8; phase++)
        begin
            unique case (phase)
                0: begin b = 7'd100; p = 16'd1; end
                1: begin b = 7'd0;   p = 16'd2; end
                2: begin b = 7'd127; p = 16'd3; end
                3: begin b = 7'd50;  p = 16'd0; end
                4: begin
                    b = 7'($urandom_range(0, 100));
                    p = 16'($urandom_range(1, 6));
                end
                5: begin b = 7'($urandom_range(0, 100)); p = 16'hFFFF; end
                6: begin
                    b = 7'($urandom_range(101, 127));
                    p = 16'($urandom_range(1, 5));
                end
                default: begin
                    b = 7'($urandom_range(0, 127));
                    p = 16'($urandom_range(1, 12));
                end
            endcase
            set_config(b, p, 9'($urandom_range(0, 511)));
            src_idle_en  = (phase != 2);
            sink_idle_en = (phase != 2 && phase != 5);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    send_item(make_item(OP_TICK, 6'($urandom_range(0, 63)),
                                        8'($urandom_range(0, 255))));
                    n++;
                end
                else if (r < 80)
                begin
                    // fill a run of consecutive bytes in order, as a frame update would
                    burst = $urandom_range(1, ROW_BYTES_DEF);
                    base  = 6'($urandom_range(0, 63));
                    for (int k = 0; k < burst; k++)
                    begin
                        send_item(make_item(OP_WRITE, 6'(base + k),
                                            8'($urandom_range(0, 255))));
                        n++;
                    end
                end
                else if (r < 92)
                begin
                    send_item(make_item(OP_SWAP, 6'($urandom_range(0, 63)),
                                        8'($urandom_range(0, 255))));
                    n++;
                end
                else
                begin
                    send_item(make_item(OP_NONE, 6'($urandom_range(0, 63)),
                                        8'($urandom_range(0, 255))));
                    n++;
                end
                // source holds off mid-phase until the block is empty
                if (phase == 4 && n == PHASE_ITEMS / 2)
                    wait_drain();
            end
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial
    begin
        reset_scan_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_brightness_edges();
        test_field_extremes();
        test_period_edges();
        test_random_phases();
        wait_drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
